// ----- rtl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg: shared definitions for the page frame allocator
// Sizes, command and status codes, table entry layout and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int FREE_DEPTH  = 1024;
  localparam int TABLE_DEPTH = 1024;
  localparam int PAGE_BYTES  = 4096;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_W       = 32 - PAGE_SHIFT;
  localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
  localparam int STK_AW     = $clog2(FREE_DEPTH);
  localparam int TBL_AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [15:0] OWNER_NONE = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_FREE    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_INSPECT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  localparam logic [1:0] CFG_KERNEL_END  = 2'd0;
  localparam logic [1:0] CFG_PHYS_TOP    = 2'd1;
  localparam logic [1:0] CFG_KERNEL_BASE = 2'd2;
  localparam logic [1:0] CFG_TRACKING    = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        used;
    logic [15:0] owner;
    logic [31:0] tick;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
    logic lookup;
    logic finish;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic clear_last;
  } dp_stat_t;

  // True when a frame index falls inside the owner table.
  function automatic logic in_table(input logic [31:0] idx);
    return idx < 32'(TABLE_DEPTH);
  endfunction

endpackage

// ----- rtl/pfa_datapath.sv -----
// ----------------------------------------------------------------------------
// pfa_datapath: registers, free stack and owner table
// Holds the configuration registers, the captured command, the LIFO of
// free page numbers, the frame ownership table and the result register.
// ----------------------------------------------------------------------------
module pfa_datapath import pfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            ctl,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         cmd,
  input  logic [31:0]        page_addr,
  input  logic [9:0]         frame_sel,
  input  logic signed [15:0] owner_id,
  input  logic [31:0]        now_tick,
  output logic [1:0]         status,
  output logic [31:0]        alloc_addr,
  output logic               entry_allocated,
  output logic signed [15:0] entry_owner,
  output logic [31:0]        entry_tick,
  output logic [19:0]        entry_index
);

  logic [31:0] kernel_end;
  logic [31:0] phys_top;
  logic [31:0] kernel_base;
  logic        tracking;

  cmd_t        cmd_q;
  logic [31:0] page_addr_q;
  logic [9:0]  frame_sel_q;
  logic [15:0] owner_q;
  logic [31:0] tick_q;

  logic [CNT_W-1:0]  count;
  logic [TBL_AW-1:0] clr_addr;

  logic [PG_W-1:0] stack_mem [FREE_DEPTH];
  logic [PG_W-1:0] stack_rdata;
  entry_t          tbl_mem [TABLE_DEPTH];
  entry_t          tbl_rdata;

  logic [31:0]     alloc_addr_q;
  logic [PG_W-1:0] alloc_idx_q;

  logic [31:0]       phys;
  logic [PG_W-1:0]   free_idx;
  logic              free_bad;
  logic              stack_full;
  logic              free_push;
  logic              pop;
  logic [STK_AW-1:0] count_m1;
  logic [31:0]       lk_addr;
  logic [31:0]       lk_phys;
  logic [PG_W-1:0]   lk_idx;

  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  entry_t            tbl_wdata;
  logic [TBL_AW-1:0] tbl_raddr;

  logic [1:0]  res_status_next;
  logic [31:0] res_addr_next;
  entry_t      res_entry_next;
  logic [19:0] res_index_next;
  logic [1:0]  res_status;
  logic [31:0] res_addr;
  entry_t      res_entry;
  logic [19:0] res_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_end  <= 32'd0;
      phys_top    <= 32'h0E00_0000;
      kernel_base <= 32'h8000_0000;
      tracking    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_END:  kernel_end  <= cfg_data;
        CFG_PHYS_TOP:    phys_top    <= cfg_data;
        CFG_KERNEL_BASE: kernel_base <= cfg_data;
        CFG_TRACKING:    tracking    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q       <= cmd_t'(cmd);
      page_addr_q <= page_addr;
      frame_sel_q <= frame_sel;
      owner_q     <= owner_id;
      tick_q      <= now_tick;
    end
  end

  // Free address checks and the frame index of the freed page.
  assign phys       = page_addr_q - kernel_base;
  assign free_idx   = phys[31:PAGE_SHIFT];
  assign free_bad   = (|page_addr_q[PAGE_SHIFT-1:0]) || (page_addr_q < kernel_end) ||
                      (phys >= phys_top);
  assign stack_full = (count == CNT_W'(FREE_DEPTH));
  assign free_push  = ctl.exec && (cmd_q == CMD_FREE) && !free_bad && !stack_full;
  assign pop        = ctl.exec && (cmd_q == CMD_ALLOC) && (count != '0);
  assign count_m1   = STK_AW'(count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (free_push) begin
      count <= count + CNT_W'(1);
    end else if (pop) begin
      count <= count - CNT_W'(1);
    end
  end

  // The stack top is read every cycle; the alloc pops it in the exec beat
  // and uses the registered data in the lookup state that follows.
  always_ff @(posedge clk) begin
    if (free_push) begin
      stack_mem[count[STK_AW-1:0]] <= page_addr_q[31:PAGE_SHIFT];
    end
    stack_rdata <= stack_mem[count_m1];
  end

  assign lk_addr = {stack_rdata, {PAGE_SHIFT{1'b0}}};
  assign lk_phys = lk_addr - kernel_base;
  assign lk_idx  = lk_phys[31:PAGE_SHIFT];

  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      alloc_addr_q <= lk_addr;
      alloc_idx_q  <= lk_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear) begin
      clr_addr <= clr_addr + TBL_AW'(1);
    end
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = clr_addr;
    tbl_wdata = '0;
    if (ctl.clear) begin
      tbl_we = 1'b1;
    end else if (free_push && in_table(32'(free_idx))) begin
      tbl_we    = 1'b1;
      tbl_waddr = TBL_AW'(free_idx);
      tbl_wdata = '{used: 1'b0, owner: OWNER_NONE, tick: 32'd0};
    end else if (ctl.finish && (cmd_q == CMD_ALLOC) && tracking &&
                 in_table(32'(alloc_idx_q))) begin
      tbl_we    = 1'b1;
      tbl_waddr = TBL_AW'(alloc_idx_q);
      tbl_wdata = '{used: 1'b1, owner: owner_q, tick: tick_q};
    end
  end

  assign tbl_raddr = ctl.lookup ? TBL_AW'(lk_idx) : TBL_AW'(frame_sel_q);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata <= tbl_mem[tbl_raddr];
  end

  always_comb begin
    res_status_next = STAT_OK;
    res_addr_next   = 32'd0;
    res_entry_next  = '{used: 1'b0, owner: OWNER_NONE, tick: 32'd0};
    res_index_next  = 20'd0;
    if (ctl.finish) begin
      if (cmd_q == CMD_ALLOC) begin
        res_addr_next  = alloc_addr_q;
        res_index_next = 20'(alloc_idx_q);
        if (in_table(32'(alloc_idx_q))) begin
          if (tracking) begin
            res_entry_next = '{used: 1'b1, owner: owner_q, tick: tick_q};
          end else begin
            res_entry_next = tbl_rdata;
          end
        end
      end else begin
        res_index_next = 20'(frame_sel_q);
        if (in_table(32'(frame_sel_q))) begin
          res_entry_next = tbl_rdata;
        end
      end
    end else begin
      case (cmd_q)
        CMD_FREE: begin
          if (free_bad) begin
            res_status_next = STAT_BAD;
          end else begin
            res_status_next = stack_full ? STAT_FULL : STAT_OK;
            res_index_next  = 20'(free_idx);
          end
        end
        CMD_ALLOC: res_status_next = STAT_EMPTY;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      res_status <= res_status_next;
      res_addr   <= res_addr_next;
      res_entry  <= res_entry_next;
      res_index  <= res_index_next;
    end
  end

  assign stat.cmd        = cmd_q;
  assign stat.empty      = (count == '0);
  assign stat.clear_last = (clr_addr == TBL_AW'(TABLE_DEPTH - 1));

  assign status          = res_status;
  assign alloc_addr      = res_addr;
  assign entry_allocated = res_entry.used;
  assign entry_owner     = res_entry.owner;
  assign entry_tick      = res_entry.tick;
  assign entry_index     = res_index;

endmodule

// ----- rtl/pfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfa_ctrl: command sequencer
// Runs the table clearing pass after reset, then steps each command through
// exec and, as needed, stack lookup and table access; raises the result strobe.
// ----------------------------------------------------------------------------
module pfa_ctrl import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output dp_cmd_t  ctl,
  input  dp_stat_t stat
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.emit;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        case (stat.cmd)
          CMD_ALLOC: begin
            if (stat.empty) begin
              ctl.emit   = 1'b1;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_LOOKUP;
            end
          end
          CMD_INSPECT: state_next = ST_FINISH;
          default: begin
            ctl.emit   = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_LOOKUP: begin
        ctl.lookup = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        ctl.finish = 1'b1;
        ctl.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- rtl/page_frame_allocator_with_owner_table_unit.sv -----
// After start is taken, a free, an empty alloc or an unused command passes
// through exec only, an inspect through exec and finish, and a successful
// alloc through exec, lookup and finish (stack read, then owner table
// read-modify-write); done is registered from the result beat. A new command
// is taken in the cycle done is shown. After reset busy stays high while all
// TABLE_DEPTH (1024) owner table entries are cleared; the free stack is not.
// ----------------------------------------------------------------------------
// page_frame_allocator_with_owner_table_unit: page frame allocator top level
// LIFO free page list with a frame ownership table, split into a
// sequencer and a datapath.
// ----------------------------------------------------------------------------
module page_frame_allocator_with_owner_table_unit import pfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         cmd,
  input  logic [31:0]        page_addr,
  input  logic [9:0]         frame_sel,
  input  logic signed [15:0] owner_id,
  input  logic [31:0]        now_tick,
  output logic [1:0]         status,
  output logic [31:0]        alloc_addr,
  output logic               entry_allocated,
  output logic signed [15:0] entry_owner,
  output logic [31:0]        entry_tick,
  output logic [19:0]        entry_index
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  pfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl),
    .stat  (stat)
  );

  pfa_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .page_addr       (page_addr),
    .frame_sel       (frame_sel),
    .owner_id        (owner_id),
    .now_tick        (now_tick),
    .status          (status),
    .alloc_addr      (alloc_addr),
    .entry_allocated (entry_allocated),
    .entry_owner     (entry_owner),
    .entry_tick      (entry_tick),
    .entry_index     (entry_index)
  );

endmodule

// ----- rtl/pfa_checker.sv -----
// ----------------------------------------------------------------------------
// pfa_checker: port level checks for the page frame allocator
// Watches the command handshake and the result beat on the top level.
// ----------------------------------------------------------------------------
module pfa_checker import pfa_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic [31:0]        alloc_addr,
  input logic signed [15:0] entry_owner,
  input logic [19:0]        entry_index
);

  // A taken command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after a command was taken");

  // A result beat is only shown while the block is free for the next command.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // One command gives one beat, never two in a row.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

  // Rejected frees and empty allocs return no page and no entry.
  a_reject_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_BAD || status == STAT_EMPTY)) |->
      (alloc_addr == 32'd0 && entry_index == 20'd0 && entry_owner == -16'sd1))
    else $error("rejected command carried a page or entry");

endmodule

bind page_frame_allocator_with_owner_table_unit pfa_checker u_pfa_checker (.*);

// ----- tb/page_frame_allocator_with_owner_table_unit_test.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator_with_owner_table_unit_test: allocator self-checking bench
// Drives free, alloc, inspect and unused commands through the start/busy port
// under several register settings. A behavioral copy of the free page stack
// and the owner table predicts every result, and a monitor compares each
// done beat field by field.
// ----------------------------------------------------------------------------
module page_frame_allocator_with_owner_table_unit_test;
  import pfa_pkg::*;

  typedef struct packed {
    cmd_t               op;
    logic [31:0]        addr;
    logic [9:0]         sel;
    logic signed [15:0] owner;
    logic [31:0]        tick;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        alloc_addr;
    logic               used;
    logic signed [15:0] owner;
    logic [31:0]        tick;
    logic [19:0]        index;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               done;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_KERNEL_END;
  logic [31:0]        cfg_data = '0;
  logic [1:0]         cmd = CMD_NONE;
  logic [31:0]        page_addr = '0;
  logic [9:0]         frame_sel = '0;
  logic signed [15:0] owner_id = '0;
  logic [31:0]        now_tick = '0;
  logic [1:0]         status;
  logic [31:0]        alloc_addr;
  logic               entry_allocated;
  logic signed [15:0] entry_owner;
  logic [31:0]        entry_tick;
  logic [19:0]        entry_index;

  page_frame_allocator_with_owner_table_unit DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the allocator: registers, free page stack and owner table.
  logic [31:0]     kernel_end_q = 32'h0;
  logic [31:0]     phys_top_q = 32'h0E00_0000;
  logic [31:0]     kernel_base_q = 32'h8000_0000;
  logic            tracking_q = 1'b0;
  logic [PG_W-1:0] free_pages [FREE_DEPTH];
  int unsigned     free_top = 0;
  logic            frame_used [TABLE_DEPTH] = '{default: 1'b0};
  logic [15:0]     frame_owner [TABLE_DEPTH] = '{default: 16'h0};
  logic [31:0]     frame_tick [TABLE_DEPTH] = '{default: 32'h0};

  request_t    pending_q[$];
  outcome_t    outcome_q[$];
  request_t    on_port;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned mismatch_cnt = 0;
  logic [9:0]  hot_frame = '0;

  function automatic outcome_t entry_view(input logic [1:0] st, input logic [31:0] addr,
                                          input logic [31:0] idx);
    outcome_t o;
    o = '{st, addr, 1'b0, OWNER_NONE, 32'h0, idx[19:0]};
    if (idx < TABLE_DEPTH) begin
      o.used = frame_used[idx];
      o.owner = frame_owner[idx];
      o.tick = frame_tick[idx];
    end
    return o;
  endfunction

  // Applies one command to the shadow state and returns the result it gives.
  function automatic outcome_t page_outcome(input request_t r);
    outcome_t    o;
    logic [31:0] phys;
    logic [31:0] idx;
    logic [31:0] addr;
    o = '{STAT_OK, 32'h0, 1'b0, OWNER_NONE, 32'h0, 20'h0};
    case (r.op)
      CMD_FREE: begin
        phys = r.addr - kernel_base_q;
        idx = phys >> PAGE_SHIFT;
        if (r.addr[PAGE_SHIFT-1:0] != '0 || r.addr < kernel_end_q || phys >= phys_top_q) begin
          o.status = STAT_BAD;
        end else if (free_top >= FREE_DEPTH) begin
          o.status = STAT_FULL;
          o.index = idx[19:0];
        end else begin
          if (idx < TABLE_DEPTH) begin
            frame_used[idx] = 1'b0;
            frame_owner[idx] = OWNER_NONE;
            frame_tick[idx] = 32'h0;
          end
          free_pages[free_top] = r.addr[31:PAGE_SHIFT];
          free_top++;
          o.index = idx[19:0];
        end
      end
      CMD_ALLOC: begin
        if (free_top == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          free_top--;
          addr = {free_pages[free_top], {PAGE_SHIFT{1'b0}}};
          idx = (addr - kernel_base_q) >> PAGE_SHIFT;
          if (tracking_q && idx < TABLE_DEPTH) begin
            frame_used[idx] = 1'b1;
            frame_owner[idx] = r.owner;
            frame_tick[idx] = r.tick;
          end
          o = entry_view(STAT_OK, addr, idx);
        end
      end
      CMD_INSPECT: o = entry_view(STAT_OK, 32'h0, {22'h0, r.sel});
      default: ;
    endcase
    return o;
  endfunction

  function automatic request_t req(input cmd_t op, input logic [31:0] addr,
                                   input logic [9:0] sel, input logic signed [15:0] owner,
                                   input logic [31:0] tick);
    request_t r;
    r = '{op, addr, sel, owner, tick};
    return r;
  endfunction

  // Frees are mostly of aligned pages near the kernel base, so that the stack
  // and the table see real traffic; the rest is arbitrary addresses and commands.
  function automatic request_t random_request(input int unsigned free_pct);
    request_t    r;
    int unsigned pick;
    int unsigned k;
    logic [31:0] base_al;
    r.op = CMD_INSPECT;
    r.addr = $urandom;
    r.sel = 10'($urandom);
    r.owner = ($urandom_range(0, 7) == 0) ? -16'sd1 : 16'($urandom_range(0, 32767));
    r.tick = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < free_pct) begin
      r.op = CMD_FREE;
      base_al = (kernel_base_q + 32'(PAGE_BYTES - 1)) & ~32'(PAGE_BYTES - 1);
      case ($urandom_range(0, 9))
        0: ;
        1: r.addr[PAGE_SHIFT-1:0] = '0;
        2: begin
          k = $urandom_range(TABLE_DEPTH, 60000);
          r.addr = base_al + (k << PAGE_SHIFT);
        end
        default: begin
          k = $urandom_range(0, TABLE_DEPTH - 1);
          r.addr = base_al + (k << PAGE_SHIFT);
          hot_frame = 10'(k);
        end
      endcase
    end else if (pick < free_pct + 30) begin
      r.op = CMD_ALLOC;
    end else if (pick < 96) begin
      if ($urandom_range(0, 1) == 1) r.sel = hot_frame;
    end else begin
      r.op = CMD_NONE;
    end
    return r;
  endfunction

  // Driver: one command beat at a time, in bursts separated by random gaps.
  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) outcome_q.push_back(page_outcome(on_port));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          on_port = nxt;
          cmd <= nxt.op;
          page_addr <= nxt.addr;
          frame_sel <= nxt.sel;
          owner_id <= nxt.owner;
          now_tick <= nxt.tick;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatch_cnt++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, status);
        check_field("alloc_addr", want.alloc_addr, alloc_addr);
        check_field("entry_allocated", want.used, entry_allocated);
        check_field("entry_owner", want.owner, entry_owner);
        check_field("entry_tick", want.tick, entry_tick);
        check_field("entry_index", want.index, entry_index);
      end
    end
  end

  // Waits until every queued command has been taken and answered.
  task automatic settle();
    do @(negedge clk);
    while (pending_q.size() != 0 || start || outcome_q.size() != 0 || busy);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KERNEL_END:  kernel_end_q = val;
      CFG_PHYS_TOP:    phys_top_q = val;
      CFG_KERNEL_BASE: kernel_base_q = val;
      CFG_TRACKING:    tracking_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] kend, input logic [31:0] ptop,
                          input logic [31:0] kbase, input logic trk);
    write_reg(CFG_KERNEL_END, kend);
    write_reg(CFG_PHYS_TOP, ptop);
    write_reg(CFG_KERNEL_BASE, kbase);
    write_reg(CFG_TRACKING, {31'h0, trk});
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned free_pct);
    for (int unsigned i = 0; i < count; i++) pending_q.push_back(random_request(free_pct));
    settle();
  endtask

  initial begin
    logic [31:0] kbase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // The owner table is cleared after reset; nothing is written until then.
    settle();

    set_regs(32'h8010_0000, 32'h0E00_0000, 32'h8000_0000, 1'b1);
    pending_q.push_back(req(CMD_INSPECT, 32'h0, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_INSPECT, 32'h0, 10'd1023, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_ALLOC, 32'h0, 10'd0, 16'sd32767, 32'hFFFF_FFFF));
    pending_q.push_back(req(CMD_NONE, 32'hFFFF_FFFF, 10'h3FF, -16'sd1, 32'hFFFF_FFFF));
    pending_q.push_back(req(CMD_FREE, 32'h8010_0001, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_FREE, 32'h800F_F000, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_FREE, 32'h8E00_0000, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_FREE, 32'h8DFF_F000, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_FREE, 32'h8010_0000, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_FREE, 32'h803F_F000, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_ALLOC, 32'h0, 10'd0, -16'sd1, 32'h0));
    pending_q.push_back(req(CMD_ALLOC, 32'h0, 10'd0, 16'sd32767, 32'hFFFF_FFFF));
    pending_q.push_back(req(CMD_ALLOC, 32'h0, 10'd0, 16'sd5, 32'd123));
    pending_q.push_back(req(CMD_ALLOC, 32'h0, 10'd0, 16'sd7, 32'd9));
    pending_q.push_back(req(CMD_INSPECT, 32'h0, 10'd1023, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_INSPECT, 32'h0, 10'd256, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_FREE, 32'h803F_F000, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_INSPECT, 32'h0, 10'd1023, 16'sd0, 32'h0));
    settle();

    // Widest window: every aligned address is a legal free, frame indices run past the owner table.
    set_regs(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    pending_q.push_back(req(CMD_FREE, 32'hFFFF_F000, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_FREE, 32'h0000_0000, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_FREE, 32'h0000_1000, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_ALLOC, 32'h0, 10'd0, 16'sd3, 32'd77));
    pending_q.push_back(req(CMD_ALLOC, 32'h0, 10'd0, 16'sd3, 32'd78));
    pending_q.push_back(req(CMD_ALLOC, 32'h0, 10'd0, 16'sd3, 32'd79));
    pending_q.push_back(req(CMD_FREE, 32'hFFFF_FFFF, 10'd0, 16'sd0, 32'h0));
    pending_q.push_back(req(CMD_INSPECT, 32'h0, 10'd0, 16'sd0, 32'h0));
    settle();

    set_regs(32'h8000_0000, 32'h0E00_0000, 32'h8000_0000, 1'b1);
    random_phase(170, 45);

    set_regs(32'h0, 32'h0020_0000, 32'hFFFF_F000, 1'b1);
    random_phase(170, 45);

    // Push the stack past its depth, then work it with allocations.
    set_regs(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    for (int i = 0; i < FREE_DEPTH + 6; i++) begin
      pending_q.push_back(req(CMD_FREE,
                              32'h8000_0000 + ($urandom_range(0, TABLE_DEPTH + 63) << PAGE_SHIFT),
                              10'd0, 16'sd0, 32'h0));
    end
    random_phase(170, 25);

    set_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
    random_phase(60, 40);

    for (int p = 0; p < 2; p++) begin
      kbase = $urandom;
      if ($urandom_range(0, 1) == 1) kbase[PAGE_SHIFT-1:0] = '0;
      set_regs(kbase + ($urandom_range(0, 8) << PAGE_SHIFT),
               $urandom_range(32'h0010_0000, 32'h0200_0000), kbase, 1'($urandom_range(0, 1)));
      random_phase(170, 45);
    end

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
